FILE: sv/ffha_pkg.sv
// Shared types, codes and command/status bundles of the first-fit heap allocator.
package ffha_pkg;

    // Block header as stored in the header memory.
    typedef struct packed {
        logic [16:0] size;
        logic        free;
        logic [16:0] next;
        logic [16:0] prev;
    } t_hdr;

    localparam int HDR_W = $bits(t_hdr);

    // Result status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_NULL_FREE = 2'd3;

    // Bound on the number of headers one chain walk visits.
    localparam logic [16:0] ADDR_SPACE = 17'h10000;

    // Header memory read source.
    typedef enum logic [2:0] {
        R_NONE, R_CUR, R_B, R_ENEXT, R_EPREV, R_X
    } t_rop;

    // Header memory write operation.
    typedef enum logic [3:0] {
        W_NONE, W_CARVE, W_APPEND, W_SPLIT_N, W_SPLIT_FIX, W_NN_FIX,
        W_NX_FIX, W_E, W_E_USED, W_E_LINK, W_PMERGE
    } t_wop;

    // Update of the working header registers.
    typedef enum logic [2:0] {
        E_NONE, E_LOAD, E_LOAD_FREE, E_SPLIT, E_MERGE, Q_LOAD
    } t_eop;

    typedef struct packed {
        t_rop       rop;
        t_wop       wop;
        t_eop       eop;
        logic       start;
        logic       step;
        logic       advance;
        logic       carve;
        logic       grant_b;
        logic       stat_set;
        logic [1:0] stat_val;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic req_zero;
        logic started;
        logic carve_ok;
        logic free_bad;
        logic hit;
        logic can_split;
        logic rd_free;
        logic rd_next_nz;
        logic walk_more;
        logic e_next_nz;
        logic e_prev_nz;
    } t_sts;

endpackage

FILE: sv/ffha_ram.sv
// Generic simple dual-port RAM with registered read.
module ffha_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 8192
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/ffha_dp.sv
// Datapath: header memory, working header registers, arena top and result registers.
module ffha_dp #(
    parameter int ARENA_BYTES  = 65536,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [16:0]     i_cfg_arena_limit,
    input  logic            i_take,
    input  logic            i_mode,
    input  logic [15:0]     i_request_size,
    input  logic [15:0]     i_address,
    input  ffha_pkg::t_cmd  i_cmd,
    output ffha_pkg::t_sts  o_sts,
    output logic [15:0]     o_granted_address,
    output logic [1:0]      o_status
);
    import ffha_pkg::*;

    function automatic int low_zeros(int v);
        int k;
        k = 0;
        for (int j = 0; j < 7; j++) begin
            if ((((v >> j) & 1) == 0) && (k == j)) begin
                k = j + 1;
            end
        end
        return k;
    endfunction

    localparam int SH_A   = low_zeros(ALIGN_BYTES);
    localparam int SH_H   = low_zeros(HEADER_BYTES);
    localparam int SH     = (SH_A < SH_H) ? SH_A : SH_H;
    localparam int GRAIN  = 1 << SH;
    localparam int ALIM_I = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;
    localparam int DEPTH  = (ALIM_I + GRAIN - 1) / GRAIN;
    localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [16:0] ALIM = 17'(ALIM_I);
    localparam logic [16:0] HDR  = 17'(HEADER_BYTES);
    localparam logic [16:0] ALN  = 17'(ALIGN_BYTES);

    function automatic logic [IW-1:0] idx(logic [15:0] off);
        return off[SH +: IW];
    endfunction

    function automatic logic [15:0] off_of(logic [16:0] lnk);
        return 16'(lnk - 17'd1);
    endfunction

    logic [16:0] r_limit, r_top, r_s, r_cur, r_steps, r_x;
    logic        r_started, r_mode, r_req_zero;
    logic [15:0] r_addr, r_b, r_grant, r_out_grant;
    logic [1:0]  r_stat, r_out_stat;
    t_hdr        r_e, r_q;

    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    t_hdr             wdata, rd;
    logic [HDR_W-1:0] ram_rdata;
    logic [16:0]      lim_now, link_b, link_top, link_n;
    logic [17:0]      carve_end, split_need;
    logic [15:0]      n_off, addr_hdr;
    logic [16:0]      n_s;

    assign rd       = t_hdr'(ram_rdata);
    assign lim_now  = (r_limit < ALIM) ? r_limit : ALIM;
    assign carve_end  = {1'b0, r_top} + {1'b0, HDR} + {1'b0, r_s};
    assign split_need = {1'b0, r_s} + {1'b0, HDR} + {1'b0, ALN};
    assign n_off    = r_b + HDR[15:0] + r_s[15:0];
    assign addr_hdr = r_addr - HDR[15:0];
    assign link_b   = {1'b0, r_b} + 17'd1;
    assign link_top = {1'b0, r_top[15:0]} + 17'd1;
    assign link_n   = {1'b0, n_off} + 17'd1;
    assign n_s      = 17'(((32'(i_request_size) + 32'(ALIGN_BYTES) - 32'd1) / ALIGN_BYTES)
                          * ALIGN_BYTES);

    // Status toward the controller.
    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.req_zero   = r_req_zero;
        o_sts.started    = r_started;
        o_sts.carve_ok   = carve_end <= {1'b0, lim_now};
        o_sts.free_bad   = (r_addr < HDR[15:0]) || ({1'b0, addr_hdr} >= r_top);
        o_sts.hit        = rd.free && (rd.size >= r_s);
        o_sts.can_split  = {1'b0, rd.size} >= split_need;
        o_sts.rd_free    = rd.free;
        o_sts.rd_next_nz = rd.next != 17'd0;
        o_sts.walk_more  = (rd.next != 17'd0) && (r_steps < ADDR_SPACE);
        o_sts.e_next_nz  = r_e.next != 17'd0;
        o_sts.e_prev_nz  = r_e.prev != 17'd0;
    end

    // Select the read address.
    always_comb begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        unique case (i_cmd.rop)
            R_NONE:  ram_re = 1'b0;
            R_CUR:   ram_raddr = idx(off_of(r_cur));
            R_B:     ram_raddr = idx(r_b);
            R_ENEXT: ram_raddr = idx(off_of(r_e.next));
            R_EPREV: ram_raddr = idx(off_of(r_e.prev));
            R_X:     ram_raddr = idx(off_of(r_x));
            default: ram_re = 1'b0;
        endcase
    end

    // Compose the write address and header.
    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = idx(r_b);
        wdata     = r_e;
        unique case (i_cmd.wop)
            W_NONE: ram_we = 1'b0;
            W_CARVE: begin
                ram_waddr = idx(r_top[15:0]);
                wdata     = '{size: r_s, free: 1'b0, next: 17'd0, prev: 17'd0};
            end
            W_APPEND: begin
                ram_waddr = idx(r_top[15:0]);
                wdata     = '{size: r_s, free: 1'b0, next: 17'd0, prev: link_b};
            end
            W_SPLIT_N: begin
                ram_waddr = idx(n_off);
                wdata     = '{size: 17'(r_e.size - r_s - HDR), free: 1'b1,
                              next: r_e.next, prev: link_b};
            end
            W_SPLIT_FIX: begin
                ram_waddr  = idx(off_of(r_x));
                wdata      = rd;
                wdata.prev = r_e.next;
            end
            W_NN_FIX: begin
                ram_waddr  = idx(off_of(r_e.next));
                wdata      = rd;
                wdata.prev = link_b;
            end
            W_NX_FIX: begin
                ram_waddr  = idx(off_of(r_e.next));
                wdata      = rd;
                wdata.prev = r_e.prev;
            end
            W_E: wdata = r_e;
            W_E_USED: wdata.free = 1'b0;
            W_E_LINK: wdata.next = link_top;
            W_PMERGE: begin
                ram_waddr = idx(off_of(r_e.prev));
                wdata     = '{size: 17'(r_q.size + HDR + r_e.size), free: r_q.free,
                              next: r_e.next, prev: r_q.prev};
            end
            default: ram_we = 1'b0;
        endcase
    end

    ffha_ram #(.WIDTH(HDR_W), .DEPTH(DEPTH)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Hold arena state and the limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= 17'h10000;
            r_top     <= 17'd0;
            r_started <= 1'b0;
            r_steps   <= 17'd0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_arena_limit;
            end
            if (i_cmd.carve) begin
                r_top     <= carve_end[16:0];
                r_started <= 1'b1;
            end
            if (i_cmd.start) begin
                r_steps <= 17'd0;
            end else if (i_cmd.step) begin
                r_steps <= r_steps + 17'd1;
            end
        end
    end

    // Latch the transaction and advance the working registers.
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_mode     <= i_mode;
            r_req_zero <= i_request_size == 16'd0;
            r_s        <= n_s;
            r_addr     <= i_address;
        end
        if (i_cmd.start) begin
            r_b     <= addr_hdr;
            r_cur   <= 17'd1;
            r_grant <= 16'd0;
        end
        if (i_cmd.stat_set) begin
            r_stat <= i_cmd.stat_val;
        end else if (i_cmd.start) begin
            r_stat <= ST_DONE;
        end
        if (i_cmd.advance) begin
            r_cur <= rd.next;
        end
        if (i_cmd.carve) begin
            r_grant <= r_top[15:0] + HDR[15:0];
        end
        if (i_cmd.grant_b) begin
            r_grant <= r_b + HDR[15:0];
        end
        unique case (i_cmd.eop)
            E_NONE: ;
            E_LOAD: begin
                r_e <= rd;
                r_b <= off_of(r_cur);
            end
            E_LOAD_FREE: begin
                r_e.size <= rd.size;
                r_e.free <= 1'b1;
                r_e.next <= rd.next;
                r_e.prev <= rd.prev;
            end
            E_SPLIT: begin
                r_x      <= r_e.next;
                r_e.size <= r_s;
                r_e.next <= link_n;
            end
            E_MERGE: begin
                r_e.size <= 17'(r_e.size + HDR + rd.size);
                r_e.next <= rd.next;
            end
            Q_LOAD: r_q <= rd;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_out_grant <= r_grant;
            r_out_stat  <= r_stat;
        end
    end

    assign o_granted_address = r_out_grant;
    assign o_status          = r_out_stat;

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= ALIM)
        else $error("arena top beyond arena size");
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= ADDR_SPACE)
        else $error("chain walk ran past its step bound");
    a_carve_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.carve |-> carve_end <= {1'b0, lim_now})
        else $error("block carved past the limit");
endmodule

FILE: sv/ffha_ctrl.sv
// Controller: sequences allocate and free transactions over the header memory.
module ffha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  ffha_pkg::t_sts i_sts,
    output ffha_pkg::t_cmd o_cmd
);
    import ffha_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE     = 24'd1 << 0,
        S_DECODE   = 24'd1 << 1,
        S_CARVE    = 24'd1 << 2,
        S_WALK_RD  = 24'd1 << 3,
        S_WALK_CHK = 24'd1 << 4,
        S_SPLIT_WN = 24'd1 << 5,
        S_SPLIT_RX = 24'd1 << 6,
        S_SPLIT_WX = 24'd1 << 7,
        S_ALLOC_WE = 24'd1 << 8,
        S_APP_WT   = 24'd1 << 9,
        S_APP_WN   = 24'd1 << 10,
        S_FE_RD    = 24'd1 << 11,
        S_FE_CHK   = 24'd1 << 12,
        S_FN_RD    = 24'd1 << 13,
        S_FN_CHK   = 24'd1 << 14,
        S_FNN_RD   = 24'd1 << 15,
        S_FNN_WR   = 24'd1 << 16,
        S_FE_WR    = 24'd1 << 17,
        S_FP_RD    = 24'd1 << 18,
        S_FP_CHK   = 24'd1 << 19,
        S_FX_RD    = 24'd1 << 20,
        S_FX_WR    = 24'd1 << 21,
        S_FP_WR    = 24'd1 << 22,
        S_DONE     = 24'd1 << 23
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    // Decode the state into datapath commands and the next state.
    always_comb begin
        n_state      = r_state;
        cmd.rop      = R_NONE;
        cmd.wop      = W_NONE;
        cmd.eop      = E_NONE;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.advance  = 1'b0;
        cmd.carve    = 1'b0;
        cmd.grant_b  = 1'b0;
        cmd.stat_set = 1'b0;
        cmd.stat_val = ST_DONE;
        cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.start = 1'b1;
                if (i_sts.mode) begin
                    if (i_sts.free_bad) begin
                        cmd.stat_set = 1'b1;
                        cmd.stat_val = ST_NULL_FREE;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_FE_RD;
                    end
                end else if (i_sts.req_zero) begin
                    cmd.stat_set = 1'b1;
                    cmd.stat_val = ST_ZERO_SIZE;
                    n_state      = S_DONE;
                end else if (!i_sts.started) begin
                    if (i_sts.carve_ok) begin
                        n_state = S_CARVE;
                    end else begin
                        cmd.stat_set = 1'b1;
                        cmd.stat_val = ST_EXHAUSTED;
                        n_state      = S_DONE;
                    end
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_CARVE: begin
                cmd.wop   = W_CARVE;
                cmd.carve = 1'b1;
                n_state   = S_DONE;
            end
            S_WALK_RD: begin
                cmd.rop  = R_CUR;
                cmd.step = 1'b1;
                n_state  = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                cmd.eop = E_LOAD;
                if (i_sts.hit) begin
                    n_state = i_sts.can_split ? S_SPLIT_WN : S_ALLOC_WE;
                end else if (i_sts.walk_more) begin
                    cmd.advance = 1'b1;
                    n_state     = S_WALK_RD;
                end else if (i_sts.carve_ok) begin
                    n_state = S_APP_WT;
                end else begin
                    cmd.stat_set = 1'b1;
                    cmd.stat_val = ST_EXHAUSTED;
                    n_state      = S_DONE;
                end
            end
            S_SPLIT_WN: begin
                cmd.wop = W_SPLIT_N;
                cmd.eop = E_SPLIT;
                n_state = i_sts.e_next_nz ? S_SPLIT_RX : S_ALLOC_WE;
            end
            S_SPLIT_RX: begin
                cmd.rop = R_X;
                n_state = S_SPLIT_WX;
            end
            S_SPLIT_WX: begin
                cmd.wop = W_SPLIT_FIX;
                n_state = S_ALLOC_WE;
            end
            S_ALLOC_WE: begin
                cmd.wop     = W_E_USED;
                cmd.grant_b = 1'b1;
                n_state     = S_DONE;
            end
            S_APP_WT: begin
                cmd.wop = W_E_LINK;
                n_state = S_APP_WN;
            end
            S_APP_WN: begin
                cmd.wop   = W_APPEND;
                cmd.carve = 1'b1;
                n_state   = S_DONE;
            end
            S_FE_RD: begin
                cmd.rop = R_B;
                n_state = S_FE_CHK;
            end
            S_FE_CHK: begin
                cmd.eop = E_LOAD_FREE;
                n_state = i_sts.rd_next_nz ? S_FN_RD : S_FE_WR;
            end
            S_FN_RD: begin
                cmd.rop = R_ENEXT;
                n_state = S_FN_CHK;
            end
            S_FN_CHK: begin
                if (i_sts.rd_free) begin
                    cmd.eop = E_MERGE;
                    n_state = i_sts.rd_next_nz ? S_FNN_RD : S_FE_WR;
                end else begin
                    n_state = S_FE_WR;
                end
            end
            S_FNN_RD: begin
                cmd.rop = R_ENEXT;
                n_state = S_FNN_WR;
            end
            S_FNN_WR: begin
                cmd.wop = W_NN_FIX;
                n_state = S_FE_WR;
            end
            S_FE_WR: begin
                cmd.wop = W_E;
                n_state = i_sts.e_prev_nz ? S_FP_RD : S_DONE;
            end
            S_FP_RD: begin
                cmd.rop = R_EPREV;
                n_state = S_FP_CHK;
            end
            S_FP_CHK: begin
                cmd.eop = Q_LOAD;
                if (i_sts.rd_free) begin
                    n_state = i_sts.e_next_nz ? S_FX_RD : S_FP_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FX_RD: begin
                cmd.rop = R_ENEXT;
                n_state = S_FX_WR;
            end
            S_FX_WR: begin
                cmd.wop = W_NX_FIX;
                n_state = S_FP_WR;
            end
            S_FP_WR: begin
                cmd.wop = W_PMERGE;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result until the downstream side takes the transaction.
    assign n_out_valid = (r_out_valid && i_out_stall) || cmd.out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_take      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> cmd.wop == W_NONE)
        else $error("header write while idle");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result overwrote a stalled result");
    a_take_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_state == S_DECODE)
        else $error("accepted transaction not decoded");
endmodule

FILE: sv/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing.
// First-fit heap allocator over a byte arena of block headers kept in one header
// memory (one read and one write port, registered read). A transaction is
// accepted, decoded and then handed to the output register. An allocate walks
// the chain first-fit and then splits, marks or appends; a free merges the
// block with whichever of its neighbors are free. The walk over the chain,
// one header per registered memory read, sets the allocate time. The output
// register lets a result wait while the next transaction is accepted. The
// arena_limit register resets to 65536 and is to be written only while idle;
// the block itself does not enforce this.
module first_fit_heap_allocator #(
    parameter int ARENA_BYTES  = 65536,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_granted_address,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_arena_limit
);
    import ffha_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic take;

    // Sequence each transaction.
    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Hold headers and arena state.
    ffha_dp #(
        .ARENA_BYTES  (ARENA_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_arena_limit (i_cfg_arena_limit),
        .i_take            (take),
        .i_mode            (i_mode),
        .i_request_size    (i_request_size),
        .i_address         (i_address),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_granted_address (o_granted_address),
        .o_status          (o_status)
    );

    assign o_cfg_ready = 1'b1;
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the first-fit heap allocator with coalescing.
module testbench;
    import ffha_pkg::*;

    localparam int HDR_B   = 32;
    localparam int ALIGN_B = 8;
    localparam int ARENA_B = 65536;
    localparam int WALK_MAX = 65536;
    localparam longint CYCLE_LIMIT = 20000000;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct {
        logic        mode;
        logic [15:0] size;
        logic [15:0] addr;
    } t_heap_req;

    typedef struct {
        logic [15:0] grant;
        logic [1:0]  status;
    } t_heap_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_mode;
    logic [15:0] i_request_size;
    logic [15:0] i_address;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_granted_address;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_arena_limit;

    // Shadow copy of the header chain and allocator state
    logic [16:0] hdr_size [ARENA_B];
    logic        hdr_free [ARENA_B];
    logic [16:0] hdr_next [ARENA_B];
    logic [16:0] hdr_prev [ARENA_B];
    int unsigned top_shadow;
    bit          started_shadow;
    int unsigned limit_shadow;

    t_heap_req   req_q[$];
    t_heap_resp  resp_q[$];
    logic [15:0] live_q[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors;
    longint      cycles;

    first_fit_heap_allocator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_request_size    (i_request_size),
        .i_address         (i_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_arena_limit (i_cfg_arena_limit)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int unsigned eff_limit();
        int unsigned l;
        l = limit_shadow;
        if (ARENA_B < l) l = ARENA_B;
        if (32'd65536 < l) l = 32'd65536;
        return l;
    endfunction

    function automatic logic [15:0] off_of(input logic [16:0] lnk);
        return 16'(lnk - 17'd1);
    endfunction

    // Carve a block at the arena top; returns offset + 1, or 0 when full
    function automatic logic [16:0] carve_block(input int unsigned s);
        int unsigned b;
        b = top_shadow;
        if (b + HDR_B + s > eff_limit()) return 17'd0;
        hdr_size[b[15:0]] = 17'(s);
        hdr_free[b[15:0]] = 1'b0;
        hdr_next[b[15:0]] = 17'd0;
        hdr_prev[b[15:0]] = 17'd0;
        top_shadow = (b + HDR_B + s) & 32'h1FFFF;
        return {1'b0, b[15:0]} + 17'd1;
    endfunction

    function automatic t_heap_resp alloc_predict(input logic [15:0] req);
        t_heap_resp r;
        int unsigned s, steps;
        logic [16:0] blk, cur;
        logic [15:0] b, n, t;
        r.grant = 16'd0;
        if (req == 16'd0) begin
            r.status = ST_ZERO_SIZE;
            return r;
        end
        s = ((req + ALIGN_B - 1) / ALIGN_B) * ALIGN_B;
        if (!started_shadow) begin
            blk = carve_block(s);
            if (blk == 17'd0) begin
                r.status = ST_EXHAUSTED;
                return r;
            end
            started_shadow = 1'b1;
        end else begin
            // first-fit walk
            blk = 17'd0;
            cur = 17'd1;
            for (steps = 0; cur != 17'd0 && steps < WALK_MAX; steps++) begin
                if (hdr_free[off_of(cur)] && hdr_size[off_of(cur)] >= s) begin
                    blk = cur;
                    break;
                end
                cur = hdr_next[off_of(cur)];
            end
            if (blk != 17'd0) begin
                b = off_of(blk);
                // split off the tail when it can hold a header plus one unit
                if (hdr_size[b] >= s + HDR_B + ALIGN_B) begin
                    n = 16'(b + HDR_B + s);
                    hdr_size[n] = 17'(hdr_size[b] - s - HDR_B);
                    hdr_free[n] = 1'b1;
                    hdr_next[n] = hdr_next[b];
                    hdr_prev[n] = {1'b0, b} + 17'd1;
                    if (hdr_next[b] != 17'd0)
                        hdr_prev[off_of(hdr_next[b])] = {1'b0, n} + 17'd1;
                    hdr_next[b] = {1'b0, n} + 17'd1;
                    hdr_size[b] = 17'(s);
                end
                hdr_free[b] = 1'b0;
            end else begin
                blk = carve_block(s);
                if (blk == 17'd0) begin
                    r.status = ST_EXHAUSTED;
                    return r;
                end
                t = 16'd0;
                for (steps = 0; hdr_next[t] != 17'd0 && steps < WALK_MAX; steps++)
                    t = off_of(hdr_next[t]);
                hdr_next[t] = blk;
                hdr_prev[off_of(blk)] = {1'b0, t} + 17'd1;
            end
        end
        r.grant = 16'(off_of(blk) + HDR_B);
        r.status = ST_DONE;
        return r;
    endfunction

    function automatic t_heap_resp free_predict(input logic [15:0] addr);
        t_heap_resp r;
        logic [15:0] b, nb;
        logic [16:0] nn, p, nx;
        r.grant = 16'd0;
        if (addr < HDR_B || int'(addr) - HDR_B >= int'(top_shadow)) begin
            r.status = ST_NULL_FREE;
            return r;
        end
        b = addr - 16'(HDR_B);
        hdr_free[b] = 1'b1;
        // merge with a free next neighbor
        if (hdr_next[b] != 17'd0 && hdr_free[off_of(hdr_next[b])]) begin
            nb = off_of(hdr_next[b]);
            nn = hdr_next[nb];
            hdr_size[b] = 17'(hdr_size[b] + HDR_B + hdr_size[nb]);
            hdr_next[b] = nn;
            if (nn != 17'd0) hdr_prev[off_of(nn)] = {1'b0, b} + 17'd1;
        end
        // merge into a free previous neighbor
        p = hdr_prev[b];
        if (p != 17'd0 && hdr_free[off_of(p)]) begin
            nx = hdr_next[b];
            hdr_size[off_of(p)] = 17'(hdr_size[off_of(p)] + HDR_B + hdr_size[b]);
            hdr_next[off_of(p)] = nx;
            if (nx != 17'd0) hdr_prev[off_of(nx)] = p;
        end
        r.status = ST_DONE;
        return r;
    endfunction

    // Queue one transaction and its predicted response
    task automatic push_req(input logic mode, input logic [15:0] size,
                            input logic [15:0] addr, output t_heap_resp r);
        t_heap_req q;
        int idx[$];
        q.mode = mode;
        q.size = size;
        q.addr = addr;
        if (mode == MODE_ALLOC) begin
            r = alloc_predict(size);
            if (r.status == ST_DONE) live_q.push_back(r.grant);
        end else begin
            r = free_predict(addr);
            idx = live_q.find_first_index(x) with (x == addr);
            if (idx.size() != 0) live_q.delete(idx[0]);
        end
        req_q.push_back(q);
        resp_q.push_back(r);
    endtask

    task automatic gen_random_req();
        t_heap_resp r;
        logic [15:0] chain[$];
        logic [15:0] t;
        int pick, steps, k;
        pick = $urandom_range(99);
        if (pick < 55 || (pick < 88 && live_q.size() == 0)) begin
            k = $urandom_range(99);
            if (k < 3) push_req(MODE_ALLOC, 16'd0, 16'($urandom), r);
            else if (k < 10) push_req(MODE_ALLOC, 16'($urandom), 16'($urandom), r);
            else if (k < 30) push_req(MODE_ALLOC, 16'($urandom_range(1, 1024)),
                                      16'($urandom), r);
            else push_req(MODE_ALLOC, 16'($urandom_range(1, 128)), 16'($urandom), r);
        end else if (pick < 88) begin
            k = $urandom_range(live_q.size() - 1);
            push_req(MODE_FREE, 16'($urandom), live_q[k], r);
        end else if (pick < 92 && started_shadow) begin
            // free a header that is in the chain, whether used or free
            t = 16'd0;
            chain.push_back(t);
            for (steps = 0; hdr_next[t] != 17'd0 && steps < 4000; steps++) begin
                t = off_of(hdr_next[t]);
                chain.push_back(t);
            end
            k = $urandom_range(chain.size() - 1);
            push_req(MODE_FREE, 16'($urandom), 16'(chain[k] + HDR_B), r);
        end else begin
            // null, below-header or beyond-top addresses
            k = $urandom_range(2);
            if (k == 0) push_req(MODE_FREE, 16'($urandom), 16'd0, r);
            else if (k == 1) push_req(MODE_FREE, 16'($urandom),
                                      16'($urandom_range(HDR_B - 1)), r);
            else if (top_shadow + HDR_B <= 65535)
                push_req(MODE_FREE, 16'($urandom),
                         16'($urandom_range(top_shadow + HDR_B, 65535)), r);
            else push_req(MODE_FREE, 16'($urandom), 16'd0, r);
        end
    endtask

    task automatic drain();
        while (req_q.size() != 0 || resp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [16:0] lim);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_arena_limit <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_shadow = lim;
    endtask

    task automatic random_phase(input logic [16:0] lim, input int n,
                                input int sidle, input int ridle);
        drain();
        write_limit(lim);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        repeat (n) gen_random_req();
    endtask

    // Stimulus, configuration and end of run
    initial begin
        t_heap_resp r;
        logic [15:0] a2, a3, a4, a5;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = 1'b0;
        i_request_size = 16'd0;
        i_address = 16'd0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_arena_limit = 17'd0;
        errors = 0;
        send_idle_pct = 23;
        recv_idle_pct = 59;
        for (int i = 0; i < ARENA_B; i++) begin
            hdr_size[i] = '0;
            hdr_free[i] = 1'b0;
            hdr_next[i] = '0;
            hdr_prev[i] = '0;
        end
        top_shadow = 0;
        started_shadow = 1'b0;
        limit_shadow = 65536;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty heap specials, splits, merges, exhaustion
        push_req(MODE_FREE, 16'd0, 16'd40, r);
        push_req(MODE_ALLOC, 16'd0, 16'hFFFF, r);
        push_req(MODE_ALLOC, 16'd1, 16'd0, r);
        push_req(MODE_ALLOC, 16'd8, 16'd0, r);
        a2 = r.grant;
        push_req(MODE_ALLOC, 16'd200, 16'd0, r);
        a3 = r.grant;
        push_req(MODE_ALLOC, 16'd9, 16'd0, r);
        a4 = r.grant;
        push_req(MODE_ALLOC, 16'd24, 16'd0, r);
        a5 = r.grant;
        push_req(MODE_FREE, 16'hFFFF, 16'd0, r);
        push_req(MODE_FREE, 16'd0, 16'd31, r);
        push_req(MODE_FREE, 16'd0, 16'hFFFF, r);
        push_req(MODE_FREE, 16'd0, a3, r);
        push_req(MODE_ALLOC, 16'd40, 16'd0, r);
        push_req(MODE_FREE, 16'd0, a4, r);
        push_req(MODE_FREE, 16'd0, a2, r);
        push_req(MODE_FREE, 16'd0, a5, r);
        push_req(MODE_FREE, 16'd0, a2, r);
        push_req(MODE_ALLOC, 16'hFFFF, 16'd0, r);
        push_req(MODE_ALLOC, 16'd65528, 16'd0, r);
        push_req(MODE_ALLOC, 16'd300, 16'd0, r);

        random_phase(17'h1FFFF, 300, 23, 59);
        random_phase(17'd0, 30, 23, 59);
        random_phase(17'd3000, 150, 59, 23);
        random_phase(17'd65536, 200, 59, 23);
        random_phase(17'd65535, 250, 0, 0);
        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Drive request transactions; hold the payload while stalled
    always @(posedge i_clk) begin
        logic take;
        logic sent;
        take = i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (take) void'(req_q.pop_front());
            sent = i_in_valid && !take;
            if (!sent) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_mode <= req_q[0].mode;
                    i_request_size <= req_q[0].size;
                    i_address <= req_q[0].addr;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the response channel at random
    always @(posedge i_clk) begin
        if (i_rst_n) i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check each response transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_heap_resp e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (resp_q.size() == 0) begin
                $display("%0t: unexpected response grant=%0d status=%0d",
                         $time, o_granted_address, o_status);
                errors++;
            end else begin
                e = resp_q.pop_front();
                if (o_granted_address !== e.grant) begin
                    $display("%0t: granted_address expected %0d actual %0d",
                             $time, e.grant, o_granted_address);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.status, o_status);
                    errors++;
                end
            end
        end
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial cycles = 0;

endmodule
